[rtl/core/maximal_munch_token_lexer_unit_assert.svh]
// Assertion macros for the token lexer checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef MAXIMAL_MUNCH_TOKEN_LEXER_UNIT_ASSERT_SVH
`define MAXIMAL_MUNCH_TOKEN_LEXER_UNIT_ASSERT_SVH

// Property checked only while out of reset.
`define MMLEX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, including during reset.
`define MMLEX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mmlex_pkg.sv]
// Shared types, codes and DFA tables for the token lexer.
// No dependencies; used by the front, back and top level.
package mmlex_pkg;

  typedef logic [3:0] cls_t;
  typedef logic [2:0] kind_t;
  typedef logic [3:0] dstate_t;

  localparam cls_t CLS_DIGIT = 4'd0;
  localparam cls_t CLS_I     = 4'd1;
  localparam cls_t CLS_F     = 4'd2;
  localparam cls_t CLS_E     = 4'd3;
  localparam cls_t CLS_LOWER = 4'd4;
  localparam cls_t CLS_SPACE = 4'd5;
  localparam cls_t CLS_TAB   = 4'd6;
  localparam cls_t CLS_DOT   = 4'd7;
  localparam cls_t CLS_SIGN  = 4'd8;
  localparam cls_t CLS_SKIP  = 4'd9;
  localparam cls_t CLS_OTHER = 4'd10;

  localparam kind_t KIND_IDENT = 3'd0;
  localparam kind_t KIND_IF    = 3'd1;
  localparam kind_t KIND_INT   = 3'd2;
  localparam kind_t KIND_REAL  = 3'd3;
  localparam kind_t KIND_WS    = 3'd4;
  localparam kind_t KIND_ERROR = 3'd5;
  localparam kind_t KIND_NONE  = 3'd7;

  localparam dstate_t S_START   = 4'd0;
  localparam dstate_t S_I       = 4'd1;
  localparam dstate_t S_IF      = 4'd2;
  localparam dstate_t S_IDENT   = 4'd3;
  localparam dstate_t S_INT     = 4'd4;
  localparam dstate_t S_FRAC    = 4'd5;
  localparam dstate_t S_WS      = 4'd6;
  localparam dstate_t S_EXP     = 4'd7;
  localparam dstate_t S_EXPSIGN = 4'd8;
  localparam dstate_t S_EXPDIG  = 4'd9;
  localparam dstate_t S_NONE    = 4'd15;

  typedef struct packed {
    logic vld;
    cls_t cls;
  } fq_t;

  function automatic dstate_t next_state(input dstate_t s, input cls_t c);
    dstate_t ns;
    ns = S_NONE;
    case (s)
      S_START: begin
        if (c == CLS_DIGIT) ns = S_INT;
        else if (c == CLS_I) ns = S_I;
        else if (c inside {CLS_F, CLS_E, CLS_LOWER}) ns = S_IDENT;
        else if (c inside {CLS_SPACE, CLS_TAB}) ns = S_WS;
      end
      S_I: begin
        if (c == CLS_F) ns = S_IF;
        else if (c inside {CLS_DIGIT, CLS_I, CLS_E, CLS_LOWER}) ns = S_IDENT;
      end
      S_IF, S_IDENT: begin
        if (c inside {CLS_DIGIT, CLS_I, CLS_F, CLS_E, CLS_LOWER}) ns = S_IDENT;
      end
      S_INT: begin
        if (c == CLS_DIGIT) ns = S_INT;
        else if (c == CLS_DOT) ns = S_FRAC;
        else if (c == CLS_E) ns = S_EXP;
      end
      S_FRAC: begin
        if (c == CLS_DIGIT) ns = S_FRAC;
      end
      S_EXP: begin
        if (c inside {CLS_DIGIT, CLS_SIGN}) ns = S_EXPSIGN;
      end
      S_EXPSIGN, S_EXPDIG: begin
        if (c == CLS_DIGIT) ns = S_EXPDIG;
      end
      default: ns = S_NONE;
    endcase
    return ns;
  endfunction

  function automatic kind_t kind_of(input dstate_t s);
    kind_t k;
    case (s)
      S_I, S_IDENT:      k = KIND_IDENT;
      S_IF:              k = KIND_IF;
      S_INT:             k = KIND_INT;
      S_FRAC, S_EXPDIG:  k = KIND_REAL;
      S_WS:              k = KIND_WS;
      default:           k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/mmlex_front.sv]
// Front end: accepts requests, classifies each byte and queues the class.
// Depends on mmlex_pkg.
module mmlex_front import mmlex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       in_end_of_input,
  output fq_t        fq,
  input  logic       fq_pop
);

  localparam logic [1:0] FQ_FULL = 2'd2;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_Z   = 8'h7A;
  localparam logic [7:0] CH_I   = 8'h69;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_E   = 8'h65;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_PLS = 8'h2B;
  localparam logic [7:0] CH_MIN = 8'h2D;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  cls_t       cls;
  cls_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  always_comb begin
    if (in_end_of_input) cls = CLS_SKIP;
    else if (in_byte_in >= CH_0 && in_byte_in <= CH_9) cls = CLS_DIGIT;
    else if (in_byte_in == CH_I) cls = CLS_I;
    else if (in_byte_in == CH_F) cls = CLS_F;
    else if (in_byte_in == CH_E) cls = CLS_E;
    else if (in_byte_in >= CH_A && in_byte_in <= CH_Z) cls = CLS_LOWER;
    else if (in_byte_in == CH_SP) cls = CLS_SPACE;
    else if (in_byte_in == CH_TAB) cls = CLS_TAB;
    else if (in_byte_in == CH_DOT) cls = CLS_DOT;
    else if (in_byte_in == CH_PLS || in_byte_in == CH_MIN) cls = CLS_SIGN;
    else if (in_byte_in == CH_NL || in_byte_in == CH_NUL) cls = CLS_SKIP;
    else cls = CLS_OTHER;
  end

  assign in_stall = (cnt_r == FQ_FULL);
  assign push     = in_valid && !in_stall;
  assign fq.vld   = (cnt_r != 2'd0);
  assign fq.cls   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = fq_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !fq_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && fq_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

endmodule

[rtl/core/mmlex_back.sv]
// Back end: steps the longest-match DFA one class per cycle if not stalled,
// replays kept bytes on a failed match, drives the output reg. Uses mmlex_pkg.
module mmlex_back import mmlex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fq_t        fq,
  output logic       fq_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_token_kind,
  output logic       out_last_in_run
);

  dstate_t    dfa_r, dfa_nxt;
  kind_t      acc_r, acc_nxt;
  cls_t       pend_r [2];
  cls_t       pend_nxt [2];
  logic [1:0] pcnt_r, pcnt_nxt;
  cls_t       wq_r [3];
  cls_t       wq_nxt [3];
  logic [1:0] wlen_r, wlen_nxt;
  logic       busy_r, busy_nxt;
  logic       hold_v_r, hold_v_nxt;
  kind_t      hold_kind_r, hold_kind_nxt;
  logic       out_valid_r, out_valid_nxt;
  kind_t      out_kind_r, out_kind_nxt;
  logic       out_last_r, out_last_nxt;

  cls_t       c;
  dstate_t    ns;
  kind_t      nk;
  logic       emit;
  kind_t      ekind;
  logic       go;
  logic       out_free;
  logic       push;
  kind_t      push_kind;
  logic       push_last;

  assign out_free = !out_valid_r || !out_stall;
  assign c        = wq_r[0];
  assign ns       = next_state(dfa_r, c);
  assign nk       = kind_of(ns);

  always_comb begin
    if (ns != S_NONE) begin
      emit  = 1'b0;
      ekind = acc_r;
    end else if (acc_r != KIND_NONE) begin
      emit  = 1'b1;
      ekind = acc_r;
    end else begin
      emit  = !(c == CLS_SKIP || c == CLS_SPACE);
      ekind = KIND_ERROR;
    end
    go = !(emit && hold_v_r) || out_free;
  end

  always_comb begin
    dfa_nxt       = dfa_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    pcnt_nxt      = pcnt_r;
    wq_nxt        = wq_r;
    wlen_nxt      = wlen_r;
    busy_nxt      = busy_r;
    hold_v_nxt    = hold_v_r;
    hold_kind_nxt = hold_kind_r;
    fq_pop        = 1'b0;
    push          = 1'b0;
    push_kind     = hold_kind_r;
    push_last     = 1'b0;

    if (!busy_r) begin
      if (fq.vld) begin
        fq_pop    = 1'b1;
        wq_nxt[0] = fq.cls;
        wlen_nxt  = 2'd1;
        busy_nxt  = 1'b1;
      end
    end else if (wlen_r == 2'd0) begin
      if (!hold_v_r) begin
        busy_nxt = 1'b0;
      end else if (out_free) begin
        push       = 1'b1;
        push_last  = 1'b1;
        hold_v_nxt = 1'b0;
        busy_nxt   = 1'b0;
      end
    end else if (go) begin
      if (emit) begin
        push          = hold_v_r;
        hold_v_nxt    = 1'b1;
        hold_kind_nxt = ekind;
      end
      if (ns != S_NONE) begin
        wq_nxt[0] = wq_r[1];
        wq_nxt[1] = wq_r[2];
        wlen_nxt  = wlen_r - 2'd1;
        dfa_nxt   = ns;
        if (nk != KIND_NONE) begin
          acc_nxt  = nk;
          pcnt_nxt = 2'd0;
        end else if (pcnt_r < 2'd2) begin
          pend_nxt[pcnt_r[0]] = c;
          pcnt_nxt            = pcnt_r + 2'd1;
        end
      end else if (acc_r != KIND_NONE) begin
        case (pcnt_r)
          2'd1: begin
            wq_nxt[0] = pend_r[0];
            wq_nxt[1] = wq_r[0];
            wq_nxt[2] = wq_r[1];
          end
          2'd2: begin
            wq_nxt[0] = pend_r[0];
            wq_nxt[1] = pend_r[1];
            wq_nxt[2] = wq_r[0];
          end
          default: begin
          end
        endcase
        wlen_nxt = wlen_r + pcnt_r;
        dfa_nxt  = S_START;
        acc_nxt  = KIND_NONE;
        pcnt_nxt = 2'd0;
      end else begin
        wq_nxt[0] = wq_r[1];
        wq_nxt[1] = wq_r[2];
        wlen_nxt  = wlen_r - 2'd1;
        dfa_nxt   = S_START;
        pcnt_nxt  = 2'd0;
      end
    end
  end

  always_comb begin
    out_kind_nxt = out_kind_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = push_kind;
      out_last_nxt  = push_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfa_r       <= S_START;
      acc_r       <= KIND_NONE;
      pcnt_r      <= 2'd0;
      wlen_r      <= 2'd0;
      busy_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dfa_r       <= dfa_nxt;
      acc_r       <= acc_nxt;
      pcnt_r      <= pcnt_nxt;
      wlen_r      <= wlen_nxt;
      busy_r      <= busy_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r      <= pend_nxt;
    wq_r        <= wq_nxt;
    hold_kind_r <= hold_kind_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_token_kind  = out_kind_r;
  assign out_last_in_run = out_last_r;

endmodule

[rtl/core/maximal_munch_token_lexer_unit.sv]
// Top level of the longest-match token lexer.
// Instantiates mmlex_front and mmlex_back; uses mmlex_pkg.
//
// Usage: each input request carries one byte, or an end-of-input marker
// (in_end_of_input high, byte ignored). Each output request carries one
// token kind; out_last_in_run marks the final token caused by an input
// request. Many input requests cause no token, since a token is reported
// only when the following byte ends it or end of input flushes it.
// Both channels use valid and stall; a request moves when valid is high
// and stall is low.
// Flow: the front queues up to two classified bytes. The back takes one
// queued byte, steps the DFA on it and on any kept bytes that a failed match
// replays, then closes the byte, and takes no new byte before it is done.
// A token that a byte ends waits in a hold register and moves to the output
// register when another token is emitted or when that byte is closed.
// When the receiver stalls, the output register holds its token and the
// back waits only when it must hand over a second token; the front keeps
// accepting until its queue is full. Synchronous reset clears the queue,
// the DFA state and the output valid; end of input returns the DFA to its
// start state.
module maximal_munch_token_lexer_unit import mmlex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_token_kind,
  output logic       out_last_in_run
);

  fq_t  fq;
  logic fq_pop;

  mmlex_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_in      (in_byte_in),
    .in_end_of_input (in_end_of_input),
    .fq              (fq),
    .fq_pop          (fq_pop)
  );

  mmlex_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fq              (fq),
    .fq_pop          (fq_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_last_in_run (out_last_in_run)
  );

endmodule

[rtl/core/mmlex_checker.sv]
// Port-level checker for the token lexer, bound to the top level.
// Depends on the assertion macros header and mmlex_pkg.
`include "maximal_munch_token_lexer_unit_assert.svh"

module mmlex_checker import mmlex_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_token_kind,
  input logic       out_last_in_run
);

  `MMLEX_ASSERT_RST(a_rst_out_idle, !rst_n |=> !out_valid, "out_valid after reset")
  `MMLEX_ASSERT_RST(a_rst_in_open, !rst_n |=> !in_stall, "in_stall after reset")
  `MMLEX_ASSERT(a_kind_legal, out_valid |-> (out_token_kind <= KIND_ERROR), "bad kind")
  `MMLEX_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_token_kind) && $stable(out_last_in_run), "stalled request changed")

endmodule

bind maximal_munch_token_lexer_unit mmlex_checker u_mmlex_checker (.*);
